FILE: hdl/lmab_pkg.sv
// Package with shared types, register indexes and constants of the local-mean binarizer.
`timescale 1ns / 1ps
package lmab_pkg;

   // Default sizing of the line memory and window.
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_RADIUS_DEF = 15;

   // Fixed field and counter widths.
   localparam int ROW_W      = 12;
   localparam int HEIGHT_MAX = 4096;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int RESULT_CAP = 16;
   localparam int CAP_W      = 5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT      = 2'd3;

   // Register reset values.
   localparam logic [9:0]  WIDTH_RESET   = 10'd512;
   localparam logic [12:0] HEIGHT_RESET  = 13'd512;
   localparam logic [3:0]  RADIUS_RESET  = 4'd10;
   localparam logic [6:0]  PERCENT_RESET = 7'd92;

   // Luma weights in thousandths, rounding term and reciprocal of 1000.
   localparam int LUMA_WR     = 299;
   localparam int LUMA_WG     = 587;
   localparam int LUMA_WB     = 114;
   localparam int LUMA_ROUND  = 500;
   localparam int LUMA_DIV    = 1000;
   localparam int LUMA_RECIP  = 1049;
   localparam int LUMA_SHIFT  = 20;
   localparam int LUMA_SUM_W  = 18;
   localparam int LUMA_Q_W    = 9;

   // Threshold scale.
   localparam int PCT_SCALE = 100;

   // Input beat.
   typedef struct packed {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic pixel_white;
      logic frame_end;
   } rsp_type;

   // Divider handshake toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: hdl/lmab_luma.sv
// Three-stage RGB to luma converter with exact division by 1000.
`timescale 1ns / 1ps
module lmab_luma (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lmab_pkg::req_type in_data,
   output logic             out_valid,
   output logic [7:0]       out_luma
);

   logic                              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [lmab_pkg::LUMA_SUM_W-1:0]   s1_sum_ff, s2_sum_ff;
   logic [lmab_pkg::LUMA_Q_W-1:0]     s2_q_ff;
   logic [7:0]                        s3_luma_ff;
   logic [lmab_pkg::LUMA_SUM_W-1:0]   s1_sum_in;
   logic [lmab_pkg::LUMA_SUM_W+10:0]  s2_prod;
   logic [lmab_pkg::LUMA_Q_W+9:0]     s3_back;

   // Weighted sum with the rounding term.
   assign s1_sum_in = lmab_pkg::LUMA_SUM_W'(
      lmab_pkg::LUMA_SUM_W'(in_data.red)   * lmab_pkg::LUMA_SUM_W'(lmab_pkg::LUMA_WR) +
      lmab_pkg::LUMA_SUM_W'(in_data.green) * lmab_pkg::LUMA_SUM_W'(lmab_pkg::LUMA_WG) +
      lmab_pkg::LUMA_SUM_W'(in_data.blue)  * lmab_pkg::LUMA_SUM_W'(lmab_pkg::LUMA_WB) +
      lmab_pkg::LUMA_SUM_W'(lmab_pkg::LUMA_ROUND));

   // Reciprocal estimate is either exact or one too high.
   assign s2_prod = (lmab_pkg::LUMA_SUM_W+11)'(s1_sum_ff) *
                    (lmab_pkg::LUMA_SUM_W+11)'(lmab_pkg::LUMA_RECIP);
   assign s3_back = (lmab_pkg::LUMA_Q_W+10)'(s2_q_ff) *
                    (lmab_pkg::LUMA_Q_W+10)'(lmab_pkg::LUMA_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff <= s1_sum_in;
      s2_sum_ff <= s1_sum_ff;
      s2_q_ff   <= lmab_pkg::LUMA_Q_W'(s2_prod >> lmab_pkg::LUMA_SHIFT);
      if (s3_back > (lmab_pkg::LUMA_Q_W+10)'(s2_sum_ff)) begin
         s3_luma_ff <= 8'(s2_q_ff - 1'b1);
      end else begin
         s3_luma_ff <= 8'(s2_q_ff);
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_luma  = s3_luma_ff;

endmodule

FILE: hdl/lmab_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
`timescale 1ns / 1ps
module lmab_div #(
   parameter int SUM_W = 18,
   parameter int CNT_W = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_W-1:0]       dividend,
   input  logic [CNT_W-1:0]       divisor,
   output lmab_pkg::div_status_type status,
   output logic [SUM_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W:0]    rem_sh;
   logic              take;
   logic [CNT_W:0]    rem_diff;

   // Shift in the next dividend bit and try a subtract.
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign take     = rem_sh >= {1'b0, divisor};
   assign rem_diff = rem_sh - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(SUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], take};
         rem_ff <= take ? CNT_W'(rem_diff) : CNT_W'(rem_sh);
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

FILE: hdl/local_mean_adaptive_binarize.sv
// Timing: a pixel is stored once its luma leaves the converter; each result then
// takes one line-memory read per window pixel followed by the bit-serial mean divider.
// Throughput: one input beat at a time; the next beat is taken once all results
// it releases (at most 16) are loaded into the output register.
// Reset: synchronous; registers return to defaults, counters clear, memory is not cleared.
`timescale 1ns / 1ps
module local_mean_adaptive_binarize #(
   parameter int MAX_WIDTH  = lmab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = lmab_pkg::MAX_RADIUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lmab_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lmab_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lmab_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmab_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int RING    = 2 * MAX_RADIUS + 1;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int SLOT_W  = $clog2(RING);
   localparam int DEPTH   = RING * MAX_WIDTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WIN_MAX = RING * RING;
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int SUM_W   = $clog2(255 * WIN_MAX + 1);
   localparam int XW      = $clog2(MAX_WIDTH + MAX_RADIUS);
   localparam int ROW_W   = lmab_pkg::ROW_W;
   localparam int YW      = ROW_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LUMA   = 8'b0000_0010,
      ST_CHECK  = 8'b0000_0100,
      ST_SUM    = 8'b0000_1000,
      ST_CENTRE = 8'b0001_0000,
      ST_CWAIT  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [9:0]  width_ff;
   logic [12:0] height_ff;
   logic [3:0]  radius_ff;
   logic [6:0]  percent_ff;
   logic        csr_write, restart;

   // Frame position counters.
   logic [COL_W-1:0]  in_col_ff, out_col_ff, x0_ff, nx_ff, rd_col_ff;
   logic [ROW_W-1:0]  in_row_ff, out_row_ff, ny_ff, rd_row_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff, rd_slot_ff;
   logic              frame_rx_ff;
   logic [lmab_pkg::CAP_W-1:0] n_ff;

   // Window accumulation.
   logic              rd_pend_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [7:0]        centre_ff, mean_ff;

   // Output register.
   logic              rsp_valid_ff;
   lmab_pkg::rsp_type rsp_data_ff;

   // Effective geometry.
   logic [WID_W-1:0]  w_eff;
   logic [12:0]       h_eff;
   logic [RAD_W-1:0]  r_eff;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;
   logic [SLOT_W-1:0] ring_len;

   always_comb begin
      if (width_ff == 10'd0) begin
         w_eff = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (32'(height_ff) > lmab_pkg::HEIGHT_MAX) begin
         h_eff = 13'(lmab_pkg::HEIGHT_MAX);
      end else begin
         h_eff = height_ff;
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         r_eff = RAD_W'(MAX_RADIUS);
      end else begin
         r_eff = RAD_W'(radius_ff);
      end
   end

   assign w_last   = COL_W'(w_eff - 1'b1);
   assign h_last   = ROW_W'(h_eff - 1'b1);
   assign ring_len = SLOT_W'({r_eff, 1'b1});

   // Window bounds of the current result position.
   logic [XW-1:0]     ox_plus;
   logic [YW-1:0]     oy_plus;
   logic [COL_W-1:0]  nx_c, x0_c;
   logic [ROW_W-1:0]  ny_c;
   logic [RAD_W-1:0]  dy_c;
   logic [SLOT_W:0]   s0_wide;
   logic [SLOT_W-1:0] s0_c;
   logic              ready_c, go_c;

   always_comb begin
      ox_plus = XW'(out_col_ff) + XW'(r_eff);
      oy_plus = YW'(out_row_ff) + YW'(r_eff);
      nx_c = (ox_plus > XW'(w_last)) ? w_last : COL_W'(ox_plus);
      ny_c = (oy_plus > YW'(h_last)) ? h_last : ROW_W'(oy_plus);
      x0_c = (XW'(out_col_ff) > XW'(r_eff)) ? COL_W'(XW'(out_col_ff) - XW'(r_eff)) : '0;
      dy_c = (YW'(out_row_ff) > YW'(r_eff)) ? r_eff : RAD_W'(out_row_ff);
      if (YW'(out_slot_ff) >= YW'(dy_c)) begin
         s0_wide = (SLOT_W+1)'(out_slot_ff) - (SLOT_W+1)'(dy_c);
      end else begin
         s0_wide = (SLOT_W+1)'(out_slot_ff) + (SLOT_W+1)'(ring_len) - (SLOT_W+1)'(dy_c);
      end
      s0_c    = SLOT_W'(s0_wide);
      ready_c = frame_rx_ff || (ny_c < in_row_ff) ||
                ((ny_c == in_row_ff) && (nx_c < in_col_ff));
      go_c    = ready_c && (n_ff < lmab_pkg::CAP_W'(lmab_pkg::RESULT_CAP));
   end

   // Luma converter.
   logic       req_accept, luma_start, luma_valid;
   logic [7:0] luma;

   assign req_accept = req_valid && !req_stall;
   assign luma_start = req_accept && !req_data.mode && !frame_rx_ff;

   lmab_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (luma_start),
      .in_data   (req_data),
      .out_valid (luma_valid),
      .out_luma  (luma)
   );

   // Mean divider.
   lmab_pkg::div_status_type div_status;
   logic [SUM_W-1:0]         div_quo;
   logic                     div_start;

   assign div_start = (state_ff == ST_CWAIT);

   lmab_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   // Line memory: one write port, one registered read port.
   logic [7:0]        line_mem [DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0]  col);
      ring_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col));
   endfunction

   assign mem_we  = (state_ff == ST_LUMA) && luma_valid;
   assign wr_addr = ring_addr(in_slot_ff, in_col_ff);
   assign mem_re  = (state_ff == ST_SUM) || (state_ff == ST_CENTRE);
   assign rd_addr = (state_ff == ST_SUM) ? ring_addr(rd_slot_ff, rd_col_ff)
                                         : ring_addr(out_slot_ff, out_col_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wr_addr] <= luma;
      end
      if (mem_re) begin
         mem_q_ff <= line_mem[rd_addr];
      end
   end

   // Result decision and output slot.
   logic [14:0] lhs_c, rhs_c;
   logic        white_c, last_c, out_free;

   assign lhs_c    = 15'(centre_ff) * 15'(lmab_pkg::PCT_SCALE);
   assign rhs_c    = 15'(percent_ff) * 15'(mean_ff);
   assign white_c  = lhs_c >= rhs_c;
   assign last_c   = (out_col_ff == w_last) && (out_row_ff == h_last);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = luma_start ? ST_LUMA : ST_CHECK;
            end
         end
         ST_LUMA: begin
            if (luma_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = go_c ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if ((rd_col_ff == nx_ff) && (rd_row_ff == ny_ff)) begin
               state_in = ST_CENTRE;
            end
         end
         ST_CENTRE: begin
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_c ? ST_IDLE : ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index != lmab_pkg::CSR_PERCENT);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= lmab_pkg::WIDTH_RESET;
         height_ff    <= lmab_pkg::HEIGHT_RESET;
         radius_ff    <= lmab_pkg::RADIUS_RESET;
         percent_ff   <= lmab_pkg::PERCENT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         frame_rx_ff  <= 1'b0;
         n_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SUM);

         if (state_ff == ST_IDLE && req_accept) begin
            n_ff <= '0;
         end

         // Store position advance.
         if (mem_we) begin
            if (in_col_ff == w_last) begin
               in_col_ff <= '0;
               if (in_row_ff == h_last) begin
                  in_row_ff   <= '0;
                  in_slot_ff  <= '0;
                  frame_rx_ff <= 1'b1;
               end else begin
                  in_row_ff  <= in_row_ff + 1'b1;
                  in_slot_ff <= (in_slot_ff == SLOT_W'(ring_len - 1'b1)) ? '0
                                                                        : in_slot_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end

         // Output register drains on an accepted beat.
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Result load and result position advance.
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            n_ff         <= n_ff + 1'b1;
            if (last_c) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               in_slot_ff  <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_slot_ff <= '0;
               frame_rx_ff <= 1'b0;
            end else if (out_col_ff == w_last) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + 1'b1;
               out_slot_ff <= (out_slot_ff == SLOT_W'(ring_len - 1'b1)) ? '0
                                                                       : out_slot_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end

         // Register writes; geometry changes restart the frame.
         if (csr_write) begin
            unique case (csr_index)
               lmab_pkg::CSR_FRAME_WIDTH:  width_ff   <= csr_data[9:0];
               lmab_pkg::CSR_FRAME_HEIGHT: height_ff  <= csr_data;
               lmab_pkg::CSR_RADIUS:       radius_ff  <= csr_data[3:0];
               lmab_pkg::CSR_PERCENT:      percent_ff <= csr_data[6:0];
               default: ;
            endcase
         end
         if (restart) begin
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_slot_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_slot_ff <= '0;
            frame_rx_ff <= 1'b0;
         end
      end
   end

   // Window walk and datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         x0_ff      <= x0_c;
         nx_ff      <= nx_c;
         ny_ff      <= ny_c;
         rd_col_ff  <= x0_c;
         rd_row_ff  <= (YW'(out_row_ff) > YW'(r_eff)) ? ROW_W'(out_row_ff - ROW_W'(r_eff))
                                                      : '0;
         rd_slot_ff <= s0_c;
         sum_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         if (state_ff == ST_SUM) begin
            if (rd_col_ff == nx_ff) begin
               rd_col_ff  <= x0_ff;
               rd_row_ff  <= rd_row_ff + 1'b1;
               rd_slot_ff <= (rd_slot_ff == SLOT_W'(ring_len - 1'b1)) ? '0
                                                                     : rd_slot_ff + 1'b1;
            end else begin
               rd_col_ff <= rd_col_ff + 1'b1;
            end
         end
         if (rd_pend_ff) begin
            sum_ff <= sum_ff + SUM_W'(mem_q_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (state_ff == ST_CWAIT) begin
         centre_ff <= mem_q_ff;
      end
      if (div_status.done) begin
         mean_ff <= 8'(div_quo);
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_data_ff.pixel_white <= white_c;
         rsp_data_ff.frame_end   <= last_c;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: hdl/lmab_checker.sv
// Port-level checker for the local-mean binarizer and its bind statement.
`timescale 1ns / 1ps
module lmab_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lmab_pkg::rsp_type rsp_data,
   input logic              csr_ready
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted input beat keeps the block busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on consecutive cycles");

   // The register port never back-pressures.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind local_mean_adaptive_binarize lmab_checker u_lmab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
